@@ src/fsep_pkg.sv @@
package fsep_pkg;

   localparam int ADDR_W = 22;
   localparam int END_W  = 23;
   localparam int IDX_W  = 6;
   localparam int CODE_W = 5;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;

   localparam logic [ADDR_W-1:0] SZ_16K  = 22'h004000;
   localparam logic [ADDR_W-1:0] SZ_64K  = 22'h010000;
   localparam logic [ADDR_W-1:0] SZ_128K = 22'h020000;
   localparam logic [ADDR_W-1:0] SZ_256K = 22'h040000;

   localparam logic [MODE_W-1:0] MODE_512K = 2'd0;
   localparam logic [MODE_W-1:0] MODE_1M   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_2M   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_3M   = 2'd3;

   typedef enum logic [STAT_W-1:0] {
      STAT_SECTOR  = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_NONE    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WALK
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic rewind;
   } walk_cmd_type;

   typedef struct packed {
      logic              hit_end;
      logic              start_ok;
      logic              at_end;
      logic              last_sector;
      logic [CODE_W-1:0] code;
   } walk_stat_type;

   typedef struct packed {
      logic              push;
      status_type        status;
      logic [CODE_W-1:0] code;
      logic              last;
   } rsp_item_type;

   // bank = 4 x 16K, 1 x 64K, 7 x 128K; sectors past two banks are 256K
   function automatic logic [ADDR_W-1:0] sector_bytes(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0]  p;
      logic [ADDR_W-1:0] sz;
      p = (idx >= IDX_W'(12)) ? idx - IDX_W'(12) : idx;
      if (idx >= IDX_W'(24)) begin
         sz = SZ_256K;
      end else if (p < IDX_W'(4)) begin
         sz = SZ_16K;
      end else if (p == IDX_W'(4)) begin
         sz = SZ_64K;
      end else begin
         sz = SZ_128K;
      end
      return sz;
   endfunction

   // hardware numbering: 0-11, then 16-27, then 12-15
   function automatic logic [CODE_W-1:0] sector_code(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] c;
      if (idx < IDX_W'(12)) begin
         c = idx;
      end else if (idx < IDX_W'(24)) begin
         c = idx + IDX_W'(4);
      end else if (idx < IDX_W'(28)) begin
         c = idx - IDX_W'(12);
      end else begin
         c = idx;
      end
      return c[CODE_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] mode_sectors(input logic [MODE_W-1:0] mode);
      logic [IDX_W-1:0] n;
      unique case (mode)
         MODE_512K: n = IDX_W'(8);
         MODE_1M:   n = IDX_W'(12);
         MODE_2M:   n = IDX_W'(24);
         MODE_3M:   n = IDX_W'(28);
         default:   n = IDX_W'(8);
      endcase
      return n;
   endfunction

endpackage

@@ src/fsep_walk.sv @@
module fsep_walk #(
   parameter int MAX_SECTORS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsep_pkg::walk_cmd_type        cmd,
   input  logic [fsep_pkg::ADDR_W-1:0]   start_offset,
   input  logic [fsep_pkg::ADDR_W-1:0]   span_length,
   input  logic [fsep_pkg::MODE_W-1:0]   layout_mode,
   output fsep_pkg::walk_stat_type       stat
);
   import fsep_pkg::*;

   localparam int IW = $clog2(MAX_SECTORS + 1);

   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [END_W-1:0]  end_ff, end_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     sidx_ff, sidx_in;
   logic              smatch_ff, smatch_in;

   logic [IDX_W-1:0]  n_full;
   logic [IW-1:0]     n_used;
   logic [ADDR_W-1:0] next_pos;
   logic              hit_start;

   always_comb begin
      n_full = mode_sectors(layout_mode);
      n_used = (n_full > IDX_W'(MAX_SECTORS)) ? IW'(MAX_SECTORS) : IW'(n_full);
   end

   // the walk adder: begin of the current sector plus its size
   assign next_pos  = cur_ff + sector_bytes(IDX_W'(idx_ff));
   assign hit_start = (cur_ff == start_ff);

   assign stat.hit_end     = ({1'b0, cur_ff} == end_ff);
   assign stat.start_ok    = smatch_ff | hit_start;
   assign stat.at_end      = (idx_ff == n_used);
   assign stat.last_sector = ({1'b0, next_pos} >= end_ff);
   assign stat.code        = sector_code(IDX_W'(idx_ff));

   always_comb begin
      cur_in    = cur_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      idx_in    = idx_ff;
      sidx_in   = sidx_ff;
      smatch_in = smatch_ff;
      priority if (cmd.load) begin
         start_in  = start_offset;
         end_in    = {1'b0, start_offset} + {1'b0, span_length};
         cur_in    = '0;
         idx_in    = '0;
         smatch_in = 1'b0;
      end else if (cmd.rewind) begin
         cur_in = start_ff;
         idx_in = smatch_ff ? sidx_ff : idx_ff;
      end else if (cmd.step) begin
         cur_in = next_pos;
         idx_in = idx_ff + IW'(1);
         if (hit_start) begin
            smatch_in = 1'b1;
            sidx_in   = idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smatch_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         smatch_ff <= smatch_in;
         idx_ff    <= idx_in;
      end
      cur_ff   <= cur_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      sidx_ff  <= sidx_in;
   end

endmodule

@@ src/fsep_ctrl.sv @@
module fsep_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    out_free,
   input  fsep_pkg::walk_stat_type stat,
   output fsep_pkg::walk_cmd_type  cmd,
   output fsep_pkg::rsp_item_type  item
);
   import fsep_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      item.push   = 1'b0;
      item.status = STAT_SECTOR;
      item.code   = '0;
      item.last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         // pass over boundaries: both start and end must land on one
         S_SCAN: begin
            if (stat.hit_end && stat.start_ok) begin
               cmd.rewind = 1'b1;
               state_in   = S_WALK;
            end else if (stat.hit_end || stat.at_end) begin
               item.status = STAT_INVALID;
               if (out_free) begin
                  item.push = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_WALK: begin
            if (stat.at_end) begin
               // start sits at the flash end
               item.status = STAT_NONE;
               if (out_free) begin
                  item.push = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               item.code = stat.code;
               item.last = stat.last_sector;
               if (out_free) begin
                  item.push = 1'b1;
                  cmd.step  = 1'b1;
                  if (stat.last_sector) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/flash_sector_erase_planner_unit.sv @@
// Flash sector erase planner.
// req channel: one erase request per item (start offset, byte length).
// rsp channel: for a valid request, one item per sector to erase in address
//   order with status "sector" on tuser and its hardware code on tdata; tlast
//   marks the final one. A misaligned or oversized request gives one "invalid"
//   item, a request that starts at the flash end with zero length gives one
//   "nothing" item.
// csr: csr_wr_en writes the layout mode (flash size variant) from csr_wr_data.
// Sequence: a request is first loaded, then a boundary scan with the single
//   adder walks the map one sector per cycle, then the sectors are emitted one
//   per cycle while the rsp side takes them.
//   req_tready is high only while no request is in work; the next request is
//   taken while the last result still sits in the output register.
// A stalled rsp side holds the walk: each sector waits for a free output slot.
// Reset (synchronous) empties the output register, returns the sequencer to
//   idle and sets the layout mode to the 512K map.
module flash_sector_erase_planner_unit #(
   parameter int MAX_SECTORS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // start_offset[21:0], span_length[43:22], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // sector_code[4:0], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import fsep_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_last_ff;

   walk_cmd_type  cmd;
   walk_stat_type stat;
   rsp_item_type  item;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   fsep_walk #(
      .MAX_SECTORS(MAX_SECTORS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .start_offset(req_tdata[21:0]),
      .span_length (req_tdata[43:22]),
      .layout_mode (mode_ff),
      .stat        (stat)
   );

   fsep_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .out_free (out_free),
      .stat     (stat),
      .cmd      (cmd),
      .item     (item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_512K;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (item.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (item.push) begin
         rsp_status_ff <= item.status;
         rsp_code_ff   <= item.code;
         rsp_last_ff   <= item.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_code_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
